@@ hw/rtl/rsd_pkg.sv @@
// Shared types and constants for the radial stick deadzone unit.
package rsd_pkg;

    localparam int AXIS_W     = 16;
    localparam int MAG_W      = 16;
    localparam int RAD_W      = 32;
    localparam int DIVN_W     = 48;
    localparam int DIVD_W     = 16;
    localparam int PROD_W     = 49;
    localparam int SQRT_STEPS = 16;

    localparam logic [15:0] AXIS_MAX  = 16'd32767;
    localparam logic [15:0] DZ_CAP    = 16'd32766;
    localparam logic [15:0] DZ_RESET  = 16'd2500;
    localparam logic [31:0] SQRT_BIT0 = 32'h4000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SUM,
        ST_SQRT,
        ST_CMP,
        ST_MUL_S,
        ST_DIVS_GO,
        ST_DIVS_WAIT,
        ST_MUL_AX,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_MUL_AY,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DIVN_W-1:0]   dividend;
        logic [DIVD_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIVN_W-1:0]   quotient;
    } div_rsp_t;

endpackage

@@ hw/rtl/radial_stick_deadzone_unit.sv @@
// Radial stick deadzone with rescaling: top level and sequencer.
//
// Usage:
//   Input requests (x_in, y_in) arrive on in_valid/in_ready; one result
//   (x_out, y_out) leaves on out_valid/out_ready for every request.
//   cfg_we/cfg_wdata write the deadzone radius; write only while idle.
//   Zero radius or a zero sample passes through unchanged. Otherwise
//   one shared multiplier, a 16-step square root and one 48-step divider
//   used three times produce the result; the divider takes most of the time.
//   in_ready is high only while the sequencer is idle.
//   The result sits in an output register; a new request is taken while
//   it waits, and the sequencer holds its finished result until the
//   output register frees up when the receiver stalls.
//   Reset clears all handshake state and loads the radius with 2500.
module radial_stick_deadzone_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [15:0]               cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [rsd_pkg::AXIS_W-1:0] x_in,
    input  logic signed [rsd_pkg::AXIS_W-1:0] y_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [rsd_pkg::AXIS_W-1:0] x_out,
    output logic signed [rsd_pkg::AXIS_W-1:0] y_out
);
    import rsd_pkg::*;

    state_t              state_reg, state_next;
    logic [15:0]         radius_reg;
    logic [14:0]         dz_reg, dz_next;
    logic [16:0]         ax_reg, ax_next, ay_reg, ay_next;
    logic                xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [31:0]         scaled_reg, scaled_next;
    logic [15:0]         rx_reg, rx_next, ry_reg, ry_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [16:0]         mul_a;
    logic [31:0]         mul_b;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         xo_reg, yo_reg;
    logic                pass, load_out;
    logic [31:0]         trial;
    logic [MAG_W-1:0]    mag;
    div_req_t            dreq;
    div_rsp_t            drsp;

    rsd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    function automatic logic [15:0] sat_axis(input logic [DIVN_W-1:0] q, input logic neg);
        logic [15:0] m;
        m = (q > DIVN_W'(AXIS_MAX)) ? AXIS_MAX : {1'b0, q[14:0]};
        return neg ? 16'(-m) : m;
    endfunction

    assign pass     = (radius_reg == '0) || (x_in == '0 && y_in == '0);
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE);
    assign trial    = res_reg + bit_reg;
    assign mag      = res_reg[MAG_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = pass ? ST_FIN : ST_MUL_X;
            ST_MUL_X:     state_next = ST_MUL_Y;
            ST_MUL_Y:     state_next = ST_SUM;
            ST_SUM:       state_next = ST_SQRT;
            ST_SQRT:      if (cnt_reg == 4'(SQRT_STEPS - 1)) state_next = ST_CMP;
            ST_CMP:       state_next = (mag <= {1'b0, dz_reg}) ? ST_FIN : ST_MUL_S;
            ST_MUL_S:     state_next = ST_DIVS_GO;
            ST_DIVS_GO:   state_next = ST_DIVS_WAIT;
            ST_DIVS_WAIT: if (drsp.done) state_next = ST_MUL_AX;
            ST_MUL_AX:    state_next = ST_DIVX_GO;
            ST_DIVX_GO:   state_next = ST_DIVX_WAIT;
            ST_DIVX_WAIT: if (drsp.done) state_next = ST_MUL_AY;
            ST_MUL_AY:    state_next = ST_DIVY_GO;
            ST_DIVY_GO:   state_next = ST_DIVY_WAIT;
            ST_DIVY_WAIT: if (drsp.done) state_next = ST_FIN;
            ST_FIN:       if (load_out) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        dz_next     = dz_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        acc_next    = acc_reg;
        v_next      = v_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        cnt_next    = cnt_reg;
        scaled_next = scaled_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        mul_a       = ax_reg;
        mul_b       = 32'(ax_reg);
        dreq.start    = 1'b0;
        dreq.dividend = prod_reg[DIVN_W-1:0];
        dreq.divisor  = {1'b0, 15'(AXIS_MAX - {1'b0, dz_reg})};
        case (state_reg)
            ST_IDLE:
            begin
                xneg_next = x_in[15];
                yneg_next = y_in[15];
                ax_next   = x_in[15] ? 17'(-{x_in[15], x_in}) : {1'b0, x_in};
                ay_next   = y_in[15] ? 17'(-{y_in[15], y_in}) : {1'b0, y_in};
                dz_next   = (radius_reg > DZ_CAP) ? DZ_CAP[14:0] : radius_reg[14:0];
                rx_next   = x_in;
                ry_next   = y_in;
            end
            ST_MUL_X:
            begin
                mul_a = ax_reg;
                mul_b = 32'(ax_reg);
            end
            ST_MUL_Y:
            begin
                acc_next = prod_reg[31:0];
                mul_a    = ay_reg;
                mul_b    = 32'(ay_reg);
            end
            ST_SUM:
            begin
                v_next   = acc_reg + prod_reg[31:0];
                res_next = '0;
                bit_next = SQRT_BIT0;
                cnt_next = '0;
            end
            ST_SQRT:
            begin
                if (v_reg >= trial)
                begin
                    v_next   = v_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_CMP:
            begin
                rx_next = '0;
                ry_next = '0;
            end
            ST_MUL_S:
            begin
                mul_a = 17'(mag - {1'b0, dz_reg});
                mul_b = 32'(AXIS_MAX);
            end
            ST_DIVS_GO:   dreq.start = 1'b1;
            ST_DIVS_WAIT: if (drsp.done) scaled_next = drsp.quotient[31:0];
            ST_MUL_AX:
            begin
                mul_a = ax_reg;
                mul_b = scaled_reg;
            end
            ST_DIVX_GO:
            begin
                dreq.start   = 1'b1;
                dreq.divisor = mag;
            end
            ST_DIVX_WAIT: if (drsp.done) rx_next = sat_axis(drsp.quotient, xneg_reg);
            ST_MUL_AY:
            begin
                mul_a = ay_reg;
                mul_b = scaled_reg;
            end
            ST_DIVY_GO:
            begin
                dreq.start   = 1'b1;
                dreq.divisor = mag;
            end
            ST_DIVY_WAIT: if (drsp.done) ry_next = sat_axis(drsp.quotient, yneg_reg);
            ST_FIN: ;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radius_reg    <= DZ_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
                radius_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        dz_reg     <= dz_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        xneg_reg   <= xneg_next;
        yneg_reg   <= yneg_next;
        acc_reg    <= acc_next;
        v_reg      <= v_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        scaled_reg <= scaled_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        prod_reg   <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (load_out)
        begin
            xo_reg <= rx_reg;
            yo_reg <= ry_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_out     = xo_reg;
    assign y_out     = yo_reg;

endmodule

@@ hw/rtl/rsd_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module rsd_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  rsd_pkg::div_req_t req,
    output rsd_pkg::div_rsp_t rsp
);
    import rsd_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIVD_W-1:0]   rem_reg, rem_next;
    logic [DIVN_W-1:0]   quo_reg, quo_next;
    logic [DIVD_W-1:0]   dsr_reg, dsr_next;
    logic [DIVD_W:0]     trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[DIVN_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVD_W'(trial - {1'b0, dsr_reg}) : trial[DIVD_W-1:0];
            quo_next = {quo_reg[DIVN_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
